// ----- src/tcnm_pkg.sv -----
package tcnm_pkg;

	// Sizing of the cluster store and angle format
	localparam int MAX_CLUSTERS    = 1024;
	localparam int ANGLE_FRAC_BITS = 13;

	localparam int IDX_W = $clog2(MAX_CLUSTERS);
	localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);

	// Field widths
	localparam int CMD_W   = 2;
	localparam int PHI_W   = 16;
	localparam int Z_W     = 16;
	localparam int EN_W    = 20;
	localparam int PT_W    = 16;
	localparam int XING_W  = 8;
	localparam int STAT_W  = 3;
	localparam int IDXO_W  = 10;
	localparam int DZ_W    = 17;
	localparam int RAD_W   = 16;
	localparam int CFG_W   = 20;
	localparam int REGI_W  = 2;

	// pi in Q30, rounded to nearest in the angle format
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam int PI_FIX = int'((PI_Q30 + (64'd1 << (29 - ANGLE_FRAC_BITS)))
		>> (30 - ANGLE_FRAC_BITS));

	// Datapath widths
	localparam int TWO_PI_W  = $clog2(2 * PI_FIX + 1);
	localparam int DPHI_W    = (TWO_PI_W + 2 > 18) ? TWO_PI_W + 2 : 18;
	localparam int MAG_W     = DPHI_W - 1;
	localparam int PROD_W    = MAG_W + RAD_W;
	localparam int RND_SH    = ANGLE_FRAC_BITS - 3;
	localparam int M_W       = PROD_W + 1 - RND_SH;
	localparam int MSQ_W     = 2 * M_W;
	localparam int ADZ_W     = 16;
	localparam int DZT_W     = 2 * ADZ_W + 10;
	localparam int MET_W     = ((MSQ_W > DZT_W) ? MSQ_W : DZT_W) + 1;
	localparam int IDX_EXT_W = (IDX_W > IDXO_W) ? IDX_W : IDXO_W;

	// Commands
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_MATCH   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NONE    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_XING    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_PT      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NO_PROJ = 3'd4;

	// Register indexes
	localparam logic [REGI_W-1:0] REG_SIM_MODE    = 2'd0;
	localparam logic [REGI_W-1:0] REG_PT_CUT      = 2'd1;
	localparam logic [REGI_W-1:0] REG_ENERGY_CUT  = 2'd2;
	localparam logic [REGI_W-1:0] REG_CALO_RADIUS = 2'd3;

	localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd9350;

	// One stored cluster
	typedef struct packed {
		logic [EN_W-1:0]         energy;
		logic signed [Z_W-1:0]   z;
		logic signed [PHI_W-1:0] phi;
	} entry_t;

	// Tag that travels with each scanned entry
	typedef struct packed {
		logic             vld;
		logic             last;
		logic [IDX_W-1:0] idx;
	} tag_t;

	// Scored candidate leaving the distance pipeline
	typedef struct packed {
		logic                     vld;
		logic                     last;
		logic                     qual;
		logic [IDX_W-1:0]         idx;
		logic [MET_W-1:0]         metric;
		logic signed [DPHI_W-1:0] dphi;
		logic signed [DZ_W-1:0]   dz;
	} cand_t;

endpackage

// ----- src/tcnm_store.sv -----
module tcnm_store (
	input  logic                         clk,
	input  logic                         we,
	input  logic [tcnm_pkg::IDX_W-1:0]   waddr,
	input  tcnm_pkg::entry_t             wdata,
	input  logic [tcnm_pkg::IDX_W-1:0]   raddr,
	output tcnm_pkg::entry_t             rdata
);
	import tcnm_pkg::*;

	entry_t mem [MAX_CLUSTERS];

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/tcnm_dist.sv -----
module tcnm_dist (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tcnm_pkg::tag_t                     tag_issue,
	input  tcnm_pkg::entry_t                   rd_data,
	input  logic signed [tcnm_pkg::PHI_W-1:0]  trk_phi,
	input  logic signed [tcnm_pkg::Z_W-1:0]    trk_z,
	input  logic [tcnm_pkg::EN_W-1:0]          energy_cut,
	input  logic [tcnm_pkg::RAD_W-1:0]         calo_radius,
	output tcnm_pkg::cand_t                    cand
);
	import tcnm_pkg::*;

	localparam logic signed [DPHI_W-1:0] PI_S     = DPHI_W'(PI_FIX);
	localparam logic signed [DPHI_W-1:0] TWO_PI_S = DPHI_W'(2 * PI_FIX);
	localparam logic [PROD_W:0]          RND_ADD  = (PROD_W+1)'(1) << (RND_SH - 1);

	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic qual_s2, qual_s3, qual_s4, qual_s5;

	logic signed [DPHI_W-1:0] dphi_s2, dphi_s3, dphi_s4, dphi_s5;
	logic signed [DZ_W-1:0]   dz_s2, dz_s3, dz_s4, dz_s5;
	logic [PROD_W-1:0]        prod_s3;
	logic [2*ADZ_W-1:0]       adz2_s3;
	logic [MSQ_W-1:0]         msq_s4;
	logic [DZT_W-1:0]         dzt_s4;
	logic [MET_W-1:0]         met_s5;

	logic signed [DPHI_W-1:0] dphi_raw, dphi_hi, dphi_w;
	logic signed [DZ_W-1:0]   dz_c;
	logic [DPHI_W-1:0]        dphi_abs;
	logic [DZ_W-1:0]          dz_abs;
	logic [MAG_W-1:0]         mag_dphi;
	logic [ADZ_W-1:0]         adz;
	logic [PROD_W:0]          rsum;
	logic [M_W-1:0]           m_arc;

	// Stage 1: phi difference with wrap, z difference
	always_comb begin
		dphi_raw = DPHI_W'(rd_data.phi) - DPHI_W'(trk_phi);
		dphi_hi  = (dphi_raw > PI_S) ? dphi_raw - TWO_PI_S : dphi_raw;
		dphi_w   = (dphi_hi < -PI_S) ? dphi_hi + TWO_PI_S : dphi_hi;
		dz_c     = DZ_W'(rd_data.z) - DZ_W'(trk_z);
	end

	// Stage 2: magnitudes
	always_comb begin
		dphi_abs = dphi_s2[DPHI_W-1] ? DPHI_W'(-dphi_s2) : DPHI_W'(dphi_s2);
		dz_abs   = dz_s2[DZ_W-1] ? DZ_W'(-dz_s2) : DZ_W'(dz_s2);
		mag_dphi = dphi_abs[MAG_W-1:0];
		adz      = dz_abs[ADZ_W-1:0];
	end

	// Stage 3: round arc length to 1/8 of 0.01 cm
	always_comb begin
		rsum  = {1'b0, prod_s3} + RND_ADD;
		m_arc = rsum[PROD_W:RND_SH];
	end

	// Tags carry reset, payload does not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s1 <= tag_issue;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		// s1 -> s2
		qual_s2 <= (rd_data.energy >= energy_cut);
		dphi_s2 <= dphi_w;
		dz_s2   <= dz_c;
		// s2 -> s3: the two products
		qual_s3 <= qual_s2;
		dphi_s3 <= dphi_s2;
		dz_s3   <= dz_s2;
		prod_s3 <= PROD_W'(mag_dphi) * PROD_W'(calo_radius);
		adz2_s3 <= (2*ADZ_W)'(adz) * (2*ADZ_W)'(adz);
		// s3 -> s4: square of arc, 576 * dz^2
		qual_s4 <= qual_s3;
		dphi_s4 <= dphi_s3;
		dz_s4   <= dz_s3;
		msq_s4  <= MSQ_W'(m_arc) * MSQ_W'(m_arc);
		dzt_s4  <= (DZT_W'(adz2_s3) << 9) + (DZT_W'(adz2_s3) << 6);
		// s4 -> s5: final sum
		qual_s5 <= qual_s4;
		dphi_s5 <= dphi_s4;
		dz_s5   <= dz_s4;
		met_s5  <= MET_W'(msq_s4) + MET_W'(dzt_s4);
	end

	always_comb begin
		cand.vld    = tag_s5.vld;
		cand.last   = tag_s5.last;
		cand.qual   = tag_s5.vld & qual_s5;
		cand.idx    = tag_s5.idx;
		cand.metric = met_s5;
		cand.dphi   = dphi_s5;
		cand.dz     = dz_s5;
	end

endmodule

// ----- src/track_cluster_nearest_match.sv -----
// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------------
// request  start / busy         cmd, item_phi, item_z, cluster_energy,
//                               track_mom, track_crossing, projection_ok
// result   done (1-cycle pulse) status, cluster_index, match_dphi, best_dz
// config   wr_en                wr_index, wr_data
//
// Append and clear raise no done pulse; a rejected query or a query on an
// empty store gives its result in the next cycle. A scanning query reads
// N stored clusters: the store read port delivers one cluster per cycle
// into a five-stage distance pipeline, and done follows the last one.
// busy is high while a scan runs or drains. Reset clears the cluster count and the
// registers; the store contents are not cleared. done cannot be stalled.
module track_cluster_nearest_match (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [tcnm_pkg::CMD_W-1:0]           cmd,
	input  logic signed [tcnm_pkg::PHI_W-1:0]    item_phi,
	input  logic signed [tcnm_pkg::Z_W-1:0]      item_z,
	input  logic [tcnm_pkg::EN_W-1:0]            cluster_energy,
	input  logic [tcnm_pkg::PT_W-1:0]            track_mom,
	input  logic signed [tcnm_pkg::XING_W-1:0]   track_crossing,
	input  logic                                 projection_ok,
	input  logic                                 wr_en,
	input  logic [tcnm_pkg::REGI_W-1:0]          wr_index,
	input  logic [tcnm_pkg::CFG_W-1:0]           wr_data,
	output logic                                 done,
	output logic [tcnm_pkg::STAT_W-1:0]          status,
	output logic [tcnm_pkg::IDXO_W-1:0]          cluster_index,
	output logic signed [tcnm_pkg::PHI_W-1:0]    match_dphi,
	output logic signed [tcnm_pkg::DZ_W-1:0]     best_dz
);
	import tcnm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q;

	// Registers
	logic             sim_mode_q;
	logic [PT_W-1:0]  pt_cut_q;
	logic [EN_W-1:0]  energy_cut_q;
	logic [RAD_W-1:0] calo_radius_q;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         rd_idx_q;
	logic signed [PHI_W-1:0]  trk_phi_q;
	logic signed [Z_W-1:0]    trk_z_q;

	// Running best
	logic                     found_q;
	logic [MET_W-1:0]         best_met_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic signed [DPHI_W-1:0] win_dphi_q;
	logic signed [DZ_W-1:0]   best_dz_q;

	logic   accept, do_append, store_open;
	tag_t   tag_issue;
	entry_t wentry, rentry;
	cand_t  cand;
	logic   upd, fin_found;

	logic [IDX_W-1:0]         fin_idx;
	logic [IDX_EXT_W-1:0]     fin_idx_ext;
	logic signed [DPHI_W-1:0] fin_dphi;
	logic signed [DZ_W-1:0]   fin_dz;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start & ~busy;
	assign store_open = (count_q < CNT_W'(MAX_CLUSTERS));
	assign do_append  = accept && (cmd == CMD_APPEND) && store_open;

	// Store write on append
	always_comb begin
		wentry.phi    = item_phi;
		wentry.z      = item_z;
		wentry.energy = cluster_energy;
	end

	// Scan issue tag
	always_comb begin
		tag_issue.vld  = (state_q == ST_SCAN);
		tag_issue.last = (CNT_W'(rd_idx_q + CNT_W'(1)) == count_q);
		tag_issue.idx  = rd_idx_q[IDX_W-1:0];
	end

	tcnm_store u_store (
		.clk   (clk),
		.we    (do_append),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wentry),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rentry)
	);

	tcnm_dist u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.tag_issue   (tag_issue),
		.rd_data     (rentry),
		.trk_phi     (trk_phi_q),
		.trk_z       (trk_z_q),
		.energy_cut  (energy_cut_q),
		.calo_radius (calo_radius_q),
		.cand        (cand)
	);

	// Compare; strict less-than keeps the first on a tie
	always_comb begin
		upd         = cand.qual && (!found_q || (cand.metric < best_met_q));
		fin_found   = found_q | upd;
		fin_idx     = upd ? cand.idx : best_idx_q;
		fin_dphi    = upd ? cand.dphi : win_dphi_q;
		fin_dz      = upd ? cand.dz : best_dz_q;
		fin_idx_ext = IDX_EXT_W'(fin_idx);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sim_mode_q    <= 1'b0;
			pt_cut_q      <= '0;
			energy_cut_q  <= '0;
			calo_radius_q <= RADIUS_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SIM_MODE:    sim_mode_q    <= wr_data[0];
				REG_PT_CUT:      pt_cut_q      <= wr_data[PT_W-1:0];
				REG_ENERGY_CUT:  energy_cut_q  <= wr_data[EN_W-1:0];
				REG_CALO_RADIUS: calo_radius_q <= wr_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Track fields and best-candidate payload
	always_ff @(posedge clk) begin
		if (accept) begin
			trk_phi_q <= item_phi;
			trk_z_q   <= item_z;
		end
		if (upd) begin
			best_met_q  <= cand.metric;
			best_idx_q  <= cand.idx;
			win_dphi_q  <= cand.dphi;
			best_dz_q   <= cand.dz;
		end
	end

	// Sequencer, cluster count and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			rd_idx_q      <= '0;
			found_q       <= 1'b0;
			done          <= 1'b0;
			status        <= STAT_NONE;
			cluster_index <= '0;
			match_dphi    <= '0;
			best_dz       <= '0;
		end else begin
			done <= 1'b0;
			if (upd) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						priority case (cmd)
							CMD_APPEND: begin
								if (store_open) begin
									count_q <= CNT_W'(count_q + CNT_W'(1));
								end
							end
							CMD_CLEAR: begin
								count_q <= '0;
							end
							CMD_QUERY: begin
								cluster_index <= '0;
								match_dphi    <= '0;
								best_dz       <= '0;
								found_q       <= 1'b0;
								rd_idx_q      <= '0;
								priority if ((track_crossing != '0) && !sim_mode_q) begin
									done   <= 1'b1;
									status <= STAT_XING;
								end else if (track_mom < pt_cut_q) begin
									done   <= 1'b1;
									status <= STAT_PT;
								end else if (!projection_ok) begin
									done   <= 1'b1;
									status <= STAT_NO_PROJ;
								end else if (count_q == '0) begin
									done   <= 1'b1;
									status <= STAT_NONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (tag_issue.last) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= CNT_W'(rd_idx_q + CNT_W'(1));
					end
				end
				ST_DRAIN: begin
					if (cand.vld && cand.last) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
						if (fin_found) begin
							status        <= STAT_MATCH;
							cluster_index <= fin_idx_ext[IDXO_W-1:0];
							match_dphi    <= fin_dphi[PHI_W-1:0];
							best_dz       <= fin_dz;
						end else begin
							status        <= STAT_NONE;
							cluster_index <= '0;
							match_dphi    <= '0;
							best_dz       <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
